// ===== hdl/text_console_character_writer_assert.svh =====
// Assertion shorthands used by the checker file.
`ifndef TEXT_CONSOLE_CHARACTER_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_CHARACTER_WRITER_ASSERT_SVH

// Same-cycle implication.
`define TCCW_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tccw: same-cycle check failed");

// Next-cycle implication.
`define TCCW_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tccw: next-cycle check failed");

`endif

// ===== hdl/tccw_pkg.sv =====
`timescale 1ns / 1ps

package tccw_pkg;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = ROWS * COLUMNS;

  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int ADDR_W = $clog2(CELLS);
  localparam int CNT_W  = $clog2(CELLS + 1);

  // Port field widths
  localparam int OP_W      = 2;
  localparam int CHAR_W    = 8;
  localparam int IN_ROW_W  = 5;
  localparam int IN_COL_W  = 7;
  localparam int CUR_COL_W = 7;
  localparam int CUR_ROW_W = 5;
  localparam int LIN_W     = 11;
  localparam int CELL_W    = 16;
  localparam int ATTR_W    = 8;

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  typedef logic [COL_W-1:0]  col_t;
  typedef logic [ROW_W-1:0]  row_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [CELL_W-1:0] cell_t;

  typedef enum logic [OP_W-1:0] {
    OP_PUT   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2
  } op_t;

  localparam logic [CHAR_W-1:0] CH_BS  = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF  = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR  = 8'h0D;
  localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h20;
  localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h07;
  localparam int TAB_STEP = 8;

  // Register word index 0 (byte address 0)
  localparam logic REG_ATTR = 1'b0;

  typedef struct packed {
    logic  we;
    addr_t waddr;
    cell_t wdata;
    addr_t raddr;
  } ram_req_t;

  typedef struct packed {
    logic                 valid;
    logic [CUR_COL_W-1:0] cursor_col;
    logic [CUR_ROW_W-1:0] cursor_row;
    logic [LIN_W-1:0]     cursor_linear;
    logic                 did_scroll;
    cell_t                cell_value;
  } result_t;

  function automatic addr_t cell_addr(row_t r, col_t c);
    return addr_t'(int'(r) * COLUMNS + int'(c));
  endfunction

endpackage

// ===== hdl/tccw_ram.sv =====
`timescale 1ns / 1ps

module tccw_ram import tccw_pkg::*; (
  input  logic     clk,
  input  ram_req_t req,
  output cell_t    rdata
);

  cell_t mem [CELLS];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

// ===== hdl/tccw_cfg.sv =====
`timescale 1ns / 1ps

module tccw_cfg import tccw_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output logic [ATTR_W-1:0]  attr
);

  // word select is paddr[2]; byte offset bits are ignored
  logic hit;

  assign pready = 1'b1;
  assign hit    = (paddr[PADDR_W-1] == REG_ATTR);
  assign prdata = hit ? PDATA_W'(attr) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      attr <= RESET_ATTR;
    end else if (psel && penable && pwrite && pready && hit) begin
      attr <= pwdata[ATTR_W-1:0];
    end
  end

endmodule

// ===== hdl/tccw_engine.sv =====
`timescale 1ns / 1ps

module tccw_engine import tccw_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [OP_W-1:0]     operation,
  input  logic [CHAR_W-1:0]   char_code,
  input  logic [IN_ROW_W-1:0] cell_row,
  input  logic [IN_COL_W-1:0] cell_col,
  input  logic [ATTR_W-1:0]   attr,
  output ram_req_t            ram_req,
  input  cell_t               ram_rdata,
  output result_t             res,
  input  logic                out_free
);

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_READ, S_SCROLL, S_BLANK, S_CLEAR, S_RESULT
  } state_t;

  typedef logic [COL_W:0] colx_t;
  typedef logic [ROW_W:0] rowx_t;

  state_t state;
  col_t   cur_col;
  row_t   cur_row;
  cnt_t   cnt;
  logic   scrolled;
  logic   rd_ok;
  cell_t  value;

  logic  accept;
  colx_t ncol;
  rowx_t nrow;
  col_t  wcol;
  logic [CHAR_W-1:0] wch;
  logic  put_we;
  logic  put_scroll;
  col_t  put_col;
  row_t  put_row;
  addr_t put_addr;
  logic  rd_in_range;
  addr_t rd_addr;
  cell_t blank;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign blank    = {attr, BLANK_CHAR};

  // Cursor update for a put
  always_comb begin
    ncol   = {1'b0, cur_col};
    nrow   = {1'b0, cur_row};
    wcol   = cur_col;
    wch    = char_code;
    put_we = 1'b0;
    case (char_code)
      CH_LF: begin
        ncol = '0;
        nrow = nrow + 1'b1;
      end
      CH_CR: begin
        ncol = '0;
      end
      CH_TAB: begin
        ncol = (ncol + colx_t'(TAB_STEP)) & ~colx_t'(TAB_STEP - 1);
      end
      CH_BS: begin
        if (cur_col != '0) begin
          ncol   = ncol - 1'b1;
          wcol   = cur_col - 1'b1;
          wch    = BLANK_CHAR;
          put_we = 1'b1;
        end
      end
      default: begin
        put_we = 1'b1;
        ncol   = ncol + 1'b1;
      end
    endcase
    if (ncol >= colx_t'(COLUMNS)) begin
      ncol = '0;
      nrow = nrow + 1'b1;
    end
    put_scroll = (nrow >= rowx_t'(ROWS));
    put_row    = put_scroll ? row_t'(ROWS - 1) : nrow[ROW_W-1:0];
    put_col    = ncol[COL_W-1:0];
    put_addr   = cell_addr(cur_row, wcol);
  end

  assign rd_in_range = (int'(cell_row) < ROWS) && (int'(cell_col) < COLUMNS);
  assign rd_addr     = cell_addr(row_t'(cell_row), col_t'(cell_col));

  always_comb begin
    ram_req = '0;
    case (state)
      S_INIT: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = cnt[ADDR_W-1:0];
        ram_req.wdata = {RESET_ATTR, BLANK_CHAR};
      end
      S_IDLE: begin
        ram_req.raddr = rd_addr;
        if (accept && operation == OP_PUT) begin
          ram_req.we    = put_we;
          ram_req.waddr = put_addr;
          ram_req.wdata = {attr, wch};
        end
      end
      S_SCROLL: begin
        // read one row ahead, write the cell read in the previous cycle
        ram_req.raddr = cnt[ADDR_W-1:0];
        ram_req.we    = (cnt > cnt_t'(COLUMNS));
        ram_req.waddr = addr_t'(cnt - cnt_t'(COLUMNS + 1));
        ram_req.wdata = ram_rdata;
      end
      S_BLANK, S_CLEAR: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = cnt[ADDR_W-1:0];
        ram_req.wdata = blank;
      end
      default: begin
        ram_req = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_INIT;
      cnt     <= '0;
      cur_col <= '0;
      cur_row <= '0;
    end else begin
      case (state)
        S_INIT: begin
          if (cnt == cnt_t'(CELLS - 1)) begin
            cnt   <= '0;
            state <= S_IDLE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_IDLE: begin
          if (accept) begin
            scrolled <= (operation == OP_PUT) && put_scroll;
            value    <= '0;
            rd_ok    <= rd_in_range;
            case (operation)
              OP_PUT: begin
                cur_col <= put_col;
                cur_row <= put_row;
                if (put_scroll) begin
                  cnt   <= cnt_t'(COLUMNS);
                  state <= S_SCROLL;
                end else begin
                  state <= S_RESULT;
                end
              end
              OP_CLEAR: begin
                cur_col <= '0;
                cur_row <= '0;
                cnt     <= '0;
                state   <= S_CLEAR;
              end
              OP_READ: begin
                state <= S_READ;
              end
              default: begin
                state <= S_RESULT;
              end
            endcase
          end
        end
        S_READ: begin
          value <= rd_ok ? ram_rdata : '0;
          state <= S_RESULT;
        end
        S_SCROLL: begin
          if (cnt == cnt_t'(CELLS)) begin
            cnt   <= cnt_t'(CELLS - COLUMNS);
            state <= S_BLANK;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_BLANK, S_CLEAR: begin
          cnt <= cnt + 1'b1;
          if (cnt == cnt_t'(CELLS - 1)) begin
            state <= S_RESULT;
          end
        end
        S_RESULT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign res.valid         = (state == S_RESULT);
  assign res.cursor_col    = CUR_COL_W'(cur_col);
  assign res.cursor_row    = CUR_ROW_W'(cur_row);
  assign res.cursor_linear = LIN_W'(cell_addr(cur_row, cur_col));
  assign res.did_scroll    = scrolled;
  assign res.cell_value    = value;

endmodule

// ===== hdl/text_console_character_writer.sv =====
`timescale 1ns / 1ps

// Text console writer. Each input item is a put (character or control byte),
// a clear, or a cell read; each produces exactly one result item with the
// cursor after the operation. The screen lives in one synchronous RAM that
// takes one write and one read per cycle, so the cost of an item is set by
// how many RAM accesses it needs: a put that scrolls shifts every row up
// by one row (one row-shift read/write per cell) and then blanks the bottom
// row, and a clear blanks every cell. After reset the block sweeps the RAM
// to blank cells under attribute 0x07 and accepts no item during that time;
// attribute writes over APB are taken at any time. A finished result sits
// in an output register until taken, so the next item can start as soon as
// that register is free.

module text_console_character_writer import tccw_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [23:0]        s_tdata,  // char_code[7:0], cell_row[12:8], cell_col[19:13]
  input  logic [OP_W-1:0]    s_tuser,  // operation[1:0]
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [39:0]        m_tdata,  // cursor_col[6:0], cursor_row[11:7],
                                       // cursor_linear[22:12], did_scroll[23],
                                       // cell_value[39:24]
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  logic [ATTR_W-1:0] attr;
  ram_req_t          ram_req;
  cell_t             ram_rdata;
  result_t           res;
  logic              out_free;

  assign out_free = !m_tvalid || m_tready;

  tccw_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .attr    (attr)
  );

  tccw_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

  tccw_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .operation (s_tuser),
    .char_code (s_tdata[7:0]),
    .cell_row  (s_tdata[12:8]),
    .cell_col  (s_tdata[19:13]),
    .attr      (attr),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata),
    .res       (res),
    .out_free  (out_free)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res.valid && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid && out_free) begin
      m_tdata <= {res.cell_value, res.did_scroll, res.cursor_linear,
                  res.cursor_row, res.cursor_col};
    end
  end

endmodule

// ===== hdl/tccw_checker.sv =====
`timescale 1ns / 1ps
`include "text_console_character_writer_assert.svh"

module tccw_checker import tccw_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata
);

  logic [CUR_COL_W-1:0] ocol;
  logic [CUR_ROW_W-1:0] orow;
  logic [LIN_W-1:0]     olin;
  logic [LIN_W-1:0]     exp_lin;
  logic                 oscroll;
  logic                 col_ok;
  logic                 row_ok;

  assign ocol    = m_tdata[6:0];
  assign orow    = m_tdata[11:7];
  assign olin    = m_tdata[22:12];
  assign oscroll = m_tdata[23];
  assign exp_lin = LIN_W'(int'(orow) * COLUMNS + int'(ocol));
  assign col_ok  = (int'(ocol) < COLUMNS);
  assign row_ok  = (int'(orow) < ROWS);

  `TCCW_ASSERT_NXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  `TCCW_ASSERT_IMP(a_cursor_range, clk, rst, m_tvalid, col_ok && row_ok)
  `TCCW_ASSERT_IMP(a_linear_match, clk, rst, m_tvalid, olin == exp_lin)
  `TCCW_ASSERT_IMP(a_scroll_bottom, clk, rst, m_tvalid && oscroll, int'(orow) == ROWS - 1)
  `TCCW_ASSERT_NXT(a_one_item_busy, clk, rst, s_tvalid && s_tready, !s_tready)

endmodule

bind text_console_character_writer tccw_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import tccw_pkg::*;

  localparam logic [OP_W-1:0]    OP_UNUSED    = 2'd3;
  localparam logic [PADDR_W-1:0] ATTR_ADDR    = PADDR_W'(4 * int'(REG_ATTR));
  localparam int                 DRAIN_CYCLES = 2100;  // outlasts a scroll or a clear

  typedef struct packed {
    logic [CUR_COL_W-1:0] col;
    logic [CUR_ROW_W-1:0] row;
    logic [LIN_W-1:0]     lin;
    logic                 scrolled;
    logic [CELL_W-1:0]    cval;
  } cursor_report_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_tvalid;
  logic               s_tready;
  logic [23:0]        s_tdata;  // char_code[7:0], cell_row[12:8], cell_col[19:13]
  logic [OP_W-1:0]    s_tuser;  // operation[1:0]
  logic               m_tvalid;
  logic               m_tready;
  logic [39:0]        m_tdata;  // cursor_col[6:0], cursor_row[11:7], cursor_linear[22:12],
                                // did_scroll[23], cell_value[39:24]
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  // Shadow of the console: screen image, cursor and attribute.
  logic [CELL_W-1:0] screen_img [CELLS];
  int                crs_col;
  int                crs_row;
  logic [ATTR_W-1:0] attr_byte;

  cursor_report_t pending_reports[$];

  int n_items, n_checked, n_errors, n_scrolls, n_reads, n_clears, n_attr_writes;
  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  int rx_stall   = 0;
  int rx_hold    = 0;

  text_console_character_writer dut (.*);

  always #5 clk = ~clk;

  function automatic void blank_screen();
    int i;
    for (i = 0; i < CELLS; i++) screen_img[i] = {attr_byte, BLANK_CHAR};
    crs_col = 0;
    crs_row = 0;
  endfunction

  function automatic cursor_report_t predict_report(logic [OP_W-1:0] op, logic [CHAR_W-1:0] ch,
                                                    logic [IN_ROW_W-1:0] rr,
                                                    logic [IN_COL_W-1:0] rc);
    cursor_report_t rep;
    int i;
    rep = '0;
    if (op == OP_PUT) begin
      if (ch == CH_LF) begin
        crs_col = 0;
        crs_row++;
      end else if (ch == CH_CR) begin
        crs_col = 0;
      end else if (ch == CH_TAB) begin
        crs_col = (crs_col + TAB_STEP) & ~(TAB_STEP - 1);
      end else if (ch == CH_BS) begin
        if (crs_col > 0) begin
          crs_col--;
          screen_img[crs_row * COLUMNS + crs_col] = {attr_byte, BLANK_CHAR};
        end
      end else begin
        screen_img[crs_row * COLUMNS + crs_col] = {attr_byte, ch};
        crs_col++;
      end
      if (crs_col >= COLUMNS) begin
        crs_col = 0;
        crs_row++;
      end
      if (crs_row >= ROWS) begin
        for (i = 0; i < CELLS - COLUMNS; i++) screen_img[i] = screen_img[i + COLUMNS];
        for (i = CELLS - COLUMNS; i < CELLS; i++) screen_img[i] = {attr_byte, BLANK_CHAR};
        crs_row = ROWS - 1;
        rep.scrolled = 1'b1;
      end
    end else if (op == OP_CLEAR) begin
      blank_screen();
    end else if (op == OP_READ) begin
      if (int'(rr) < ROWS && int'(rc) < COLUMNS)
        rep.cval = screen_img[int'(rr) * COLUMNS + int'(rc)];
    end
    rep.col = CUR_COL_W'(crs_col);
    rep.row = CUR_ROW_W'(crs_row);
    rep.lin = LIN_W'(crs_row * COLUMNS + crs_col);
    return rep;
  endfunction

  // All driving tasks are entered and left at a falling edge.
  task automatic send_item(logic [OP_W-1:0] op, logic [CHAR_W-1:0] ch,
                           logic [IN_ROW_W-1:0] rr, logic [IN_COL_W-1:0] rc);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {4'b0, rc, rr, ch};
    do @(posedge clk); while (!s_tready);
    pending_reports.push_back(predict_report(op, ch, rr, rc));
    n_items++;
    if (op == OP_READ) n_reads++;
    if (op == OP_CLEAR) n_clears++;
    @(negedge clk);
  endtask

  task automatic put_byte(logic [CHAR_W-1:0] ch);
    send_item(OP_PUT, ch, IN_ROW_W'($urandom), IN_COL_W'($urandom));
  endtask

  task automatic read_cell(int r, int c);
    send_item(OP_READ, CHAR_W'($urandom), IN_ROW_W'(r), IN_COL_W'(c));
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Write the attribute, then read it back over the same port.
  task automatic write_attr(logic [ATTR_W-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ATTR_ADDR;
    pwdata  <= PDATA_W'(v);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    attr_byte = v;
    n_attr_writes++;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== PDATA_W'(v)) begin
      $display("%0t: attribute readback mismatch: expected 0x%0h, got 0x%0h",
               $time, PDATA_W'(v), prdata);
      n_errors++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, name, want, got);
      n_errors++;
    end
  endtask

  always @(posedge clk) begin
    cursor_report_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_reports.size() == 0) begin
        $display("%0t: result with no item pending: expected none, got tdata 0x%0h",
                 $time, m_tdata);
        n_errors++;
      end else begin
        want = pending_reports.pop_front();
        check_field("cursor_col", want.col, m_tdata[6:0]);
        check_field("cursor_row", want.row, m_tdata[11:7]);
        check_field("cursor_linear", want.lin, m_tdata[22:12]);
        check_field("did_scroll", want.scrolled, m_tdata[23]);
        check_field("cell_value", want.cval, m_tdata[39:24]);
        if (want.scrolled) n_scrolls++;
        n_checked++;
      end
      rx_stall = rx_idle_on ? $urandom_range(0, 7) : 0;
    end
  end

  // Receiver: a long hold requested by a test wins over the per-item stall.
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        rx_hold--;
        m_tready <= 1'b0;
      end else if (rx_stall > 0) begin
        rx_stall--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic test_reset_state();
    read_cell(0, 0);
    read_cell(ROWS - 1, COLUMNS - 1);
  endtask

  task automatic test_control_bytes();
    put_byte(8'h41);
    put_byte(8'h00);
    put_byte(8'hFF);
    put_byte(CH_TAB);
    put_byte(CH_BS);
    put_byte(CH_CR);
    put_byte(CH_BS);   // at column 0: no effect
    put_byte(CH_LF);
    read_cell(0, 1);
    read_cell(0, 2);
  endtask

  task automatic test_read_range();
    read_cell(ROWS, 0);
    read_cell(31, 127);
    read_cell(0, COLUMNS);
    send_item(OP_UNUSED, 8'hFF, 5'h1F, 7'h7F);
  endtask

  task automatic test_attribute();
    wait_idle();
    write_attr(8'hFF);
    put_byte(8'h5A);
    read_cell(1, 0);
    wait_idle();
    write_attr(8'h00);
    put_byte(CH_BS);
    read_cell(1, 0);
    send_item(OP_CLEAR, 8'h00, 5'h00, 7'h00);
    read_cell(ROWS - 1, COLUMNS - 1);
  endtask

  task automatic test_backpressure();
    int k;
    wait_idle();
    write_attr(RESET_ATTR);
    tx_idle_on = 1'b0;
    rx_hold    = 400;
    for (k = 0; k < 40; k++) begin
      if (k % 5 == 4) read_cell(0, k / 5);
      else put_byte(8'($urandom_range(8'h20, 8'h7E)));
    end
    tx_idle_on = 1'b1;
  endtask

  task automatic run_text_burst(int count, int lf_pct, int noise_pct);
    int k;
    int pick;
    for (k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 299) == 0) begin
        send_item(OP_CLEAR, CHAR_W'($urandom), IN_ROW_W'($urandom), IN_COL_W'($urandom));
      end else if (pick < noise_pct) begin
        send_item(OP_W'($urandom), CHAR_W'($urandom), IN_ROW_W'($urandom),
                  IN_COL_W'($urandom));
      end else if (pick < noise_pct + 15) begin
        read_cell($urandom_range(0, ROWS - 1), $urandom_range(0, COLUMNS - 1));
      end else if (pick < noise_pct + 15 + lf_pct) begin
        put_byte(CH_LF);
      end else if (pick < noise_pct + 21 + lf_pct) begin
        case ($urandom_range(0, 2))
          0: put_byte(CH_CR);
          1: put_byte(CH_TAB);
          default: put_byte(CH_BS);
        endcase
      end else if (pick < noise_pct + 24 + lf_pct) begin
        put_byte(CHAR_W'($urandom));
      end else begin
        put_byte(8'($urandom_range(8'h20, 8'h7E)));  // printable text
      end
    end
  endtask

  task automatic test_random_text();
    wait_idle();
    write_attr(ATTR_W'($urandom));
    run_text_burst(425, 12, 2);
    wait_idle();
    write_attr(ATTR_W'($urandom));
    rx_idle_on = 1'b0;
    run_text_burst(425, 2, 2);    // long lines, mostly wrapping
    wait_idle();
    write_attr(ATTR_W'($urandom));
    tx_idle_on = 1'b0;
    run_text_burst(425, 8, 0);
    wait_idle();
    write_attr(ATTR_W'($urandom));
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    run_text_burst(425, 10, 6);
  endtask

  initial begin
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    attr_byte = RESET_ATTR;
    blank_screen();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_control_bytes();
    test_read_range();
    test_attribute();
    test_backpressure();
    test_random_text();

    wait_idle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("Sent %0d items (%0d reads, %0d clears), checked %0d results, %0d scrolls seen.",
             n_items, n_reads, n_clears, n_checked, n_scrolls);
    $display("Attribute written %0d times, including both extremes; one long output hold.",
             n_attr_writes);
    if (n_errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("Timeout with %0d results still pending", pending_reports.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule
